>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bfa_pkg.sv
package bfa_pkg;

   localparam int FRAME_W   = 20;
   localparam int COUNT_W   = 16;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = 5;
   localparam int DATA_W    = 40;
   localparam int PAD_W     = DATA_W - FRAME_W - COUNT_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_BASE_FRAME    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POOL_FRAMES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVE_FIRST = 2'd2;

   localparam logic [FRAME_W-1:0] RST_BASE_FRAME  = 20'd0;
   localparam logic [COUNT_W-1:0] RST_POOL_FRAMES = 16'd32768;
   localparam logic               RST_RESERVE     = 1'b1;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_MARK    = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_RANGE   = 2'd2,
      ST_ALREADY = 2'd3
   } status_type;

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_INIT_BEGIN,
      DP_INIT_WORD,
      DP_ALLOC_BEGIN,
      DP_NOFREE,
      DP_SCAN,
      DP_PREP_A,
      DP_PREP_B,
      DP_MARK_BEGIN,
      DP_MARK,
      DP_REL_PREP,
      DP_REL_READ,
      DP_REL_UPDATE,
      DP_LOAD
   } dp_op_type;

   typedef struct packed {
      logic init_last;
      logic free_zero;
      logic pool_empty;
      logic scan_hit;
      logic scan_end;
      logic range_empty;
      logic rel_bad;
   } dp_status_type;

endpackage

>>> rtl/bfa_ctrl.sv
module bfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bfa_pkg::cmd_type      req_cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  bfa_pkg::dp_status_type dp_status,
   output bfa_pkg::dp_op_type    dp_op
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      S_INIT_BEGIN,
      S_INIT_RUN,
      S_IDLE,
      S_ALLOC_BEGIN,
      S_ALLOC_SCAN,
      S_MARK_PREP_A,
      S_MARK_PREP_B,
      S_MARK_BEGIN,
      S_MARK_RUN,
      S_MARK_DRAIN,
      S_REL_PREP,
      S_REL_READ,
      S_REL_CHECK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      init_rsp_ff, init_rsp_in;   // init came from a command, not reset
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      init_rsp_in  = init_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dp_op        = DP_NOP;
      case (state_ff)
         S_INIT_BEGIN: begin
            dp_op    = DP_INIT_BEGIN;
            state_in = S_INIT_RUN;
         end
         S_INIT_RUN: begin
            dp_op = DP_INIT_WORD;
            if (dp_status.init_last) begin
               state_in = init_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               dp_op = DP_CAPTURE;
               case (req_cmd)
                  CMD_INIT: begin
                     state_in    = S_INIT_BEGIN;
                     init_rsp_in = 1'b1;
                  end
                  CMD_ALLOC:   state_in = S_ALLOC_BEGIN;
                  CMD_MARK:    state_in = S_MARK_PREP_A;
                  CMD_RELEASE: state_in = S_REL_PREP;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_ALLOC_BEGIN: begin
            if (dp_status.free_zero || dp_status.pool_empty) begin
               dp_op    = DP_NOFREE;
               state_in = S_DONE;
            end else begin
               dp_op    = DP_ALLOC_BEGIN;
               state_in = S_ALLOC_SCAN;
            end
         end
         S_ALLOC_SCAN: begin
            dp_op = DP_SCAN;
            if (dp_status.scan_hit || dp_status.scan_end) begin
               state_in = S_DONE;
            end
         end
         S_MARK_PREP_A: begin
            dp_op    = DP_PREP_A;
            state_in = S_MARK_PREP_B;
         end
         S_MARK_PREP_B: begin
            dp_op    = DP_PREP_B;
            state_in = S_MARK_BEGIN;
         end
         S_MARK_BEGIN: begin
            if (dp_status.range_empty) begin
               state_in = S_DONE;
            end else begin
               dp_op    = DP_MARK_BEGIN;
               state_in = S_MARK_RUN;
            end
         end
         S_MARK_RUN: begin
            dp_op = DP_MARK;
            if (dp_status.scan_end) begin
               state_in = S_MARK_DRAIN;
            end
         end
         S_MARK_DRAIN: begin
            dp_op    = DP_MARK;   // applies the last word's count
            state_in = S_DONE;
         end
         S_REL_PREP: begin
            dp_op    = DP_REL_PREP;
            state_in = S_REL_READ;
         end
         S_REL_READ: begin
            dp_op    = DP_REL_READ;
            state_in = dp_status.rel_bad ? S_DONE : S_REL_CHECK;
         end
         S_REL_CHECK: begin
            dp_op    = DP_REL_UPDATE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_op        = DP_LOAD;
               rsp_valid_in = 1'b1;
               init_rsp_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_BEGIN;
         init_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_rsp_ff  <= init_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/bfa_dpath.sv
module bfa_dpath #(
   parameter int MAX_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfa_pkg::FRAME_W-1:0]     csr_data,
   input  logic [bfa_pkg::FRAME_W-1:0]     req_start_frame,
   input  logic [bfa_pkg::COUNT_W-1:0]     req_range_count,
   input  bfa_pkg::dp_op_type              dp_op,
   output bfa_pkg::dp_status_type          dp_status,
   output logic [bfa_pkg::FRAME_W-1:0]     rsp_frame_out,
   output bfa_pkg::status_type             rsp_status,
   output logic [bfa_pkg::COUNT_W-1:0]     rsp_free_count
);
   import bfa_pkg::*;

   localparam int WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
   localparam logic [31:0]   MAX_W     = 32'(MAX_FRAMES);

   // word index of a pool-relative frame number
   function automatic logic [AW-1:0] word_of(input logic [FRAME_W:0] rel);
      logic [31:0] t;
      t = 32'(rel) >> BIT_W;
      return t[AW-1:0];
   endfunction

   // bits of word w that lie below frame n
   function automatic logic [WORD_W-1:0] pool_mask(input logic [AW-1:0] w,
                                                   input logic [COUNT_W-1:0] n);
      logic [31:0] wb;
      logic [31:0] nn;
      logic [31:0] rem;
      wb  = 32'(w) << BIT_W;
      nn  = 32'(n);
      rem = nn - wb;
      if (nn >= wb + 32'(WORD_W)) begin
         return ALL_ONES;
      end else if (nn <= wb) begin
         return '0;
      end else begin
         return ~(ALL_ONES << rem[BIT_W-1:0]);
      end
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [BIT_W:0] pop_count(input logic [WORD_W-1:0] v);
      logic [BIT_W:0] c;
      c = '0;
      for (int i = 0; i < WORD_W; i++) begin
         c = c + (BIT_W + 1)'(v[i]);
      end
      return c;
   endfunction

   // configuration
   logic [FRAME_W-1:0] base_ff;
   logic [COUNT_W-1:0] pool_ff;
   logic               rsv_ff;

   // command operands and working state
   logic [FRAME_W-1:0] fno_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] n_init_ff;
   logic               rsv_init_ff;
   logic [AW-1:0]      ptr_ff, last_ff, first_ff, tag_ff;
   logic               issued_ff;
   logic               rdv_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [BIT_W-1:0]   lo_bit_ff, hi_bit_ff;
   logic [FRAME_W:0]   end_ff, pend_ff, hi_abs_ff;
   logic [FRAME_W-1:0] lo_abs_ff;
   logic [COUNT_W-1:0] rel_ff;
   logic               rel_bad_ff;
   logic [BIT_W:0]     pc_ff;
   logic               pcv_ff;
   logic [COUNT_W-1:0] free_ff;
   logic [FRAME_W-1:0] res_frame_ff;
   status_type         res_status_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_free_ff;

   logic [WORD_W-1:0]  frame_map [WORDS];

   logic [COUNT_W-1:0] psize;
   logic [WORD_W-1:0]  scan_word, mark_mask, init_word;
   logic [BIT_W-1:0]   hit_bit;
   logic               hit, scan_end, scan_rd;
   logic [FRAME_W:0]   rel_full, lo_rel, hi_rel_m1;
   logic               rel_bad_c;
   logic [AW-1:0]      rel_word;
   logic [31:0]        alloc_frame;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [WORD_W-1:0]  wr_data;

   assign psize = ({16'd0, pool_ff} > MAX_W) ? MAX_W[COUNT_W-1:0] : pool_ff;

   assign scan_word = rd_data_ff & pool_mask(tag_ff, psize);
   assign hit       = rdv_ff && (|scan_word);
   assign hit_bit   = lowest_bit(scan_word);
   assign scan_end  = rdv_ff && (tag_ff == last_ff);
   assign alloc_frame = ((32'(tag_ff) << BIT_W) | 32'(hit_bit)) + 32'(base_ff);

   always_comb begin
      mark_mask = ALL_ONES;
      if (tag_ff == first_ff) mark_mask = mark_mask & (ALL_ONES << lo_bit_ff);
      if (tag_ff == last_ff)  mark_mask = mark_mask & (ALL_ONES >> (5'd31 - hi_bit_ff));
   end

   assign init_word = pool_mask(ptr_ff, n_init_ff)
                    & ~(((ptr_ff == '0) && rsv_init_ff) ? 32'd1 : 32'd0);

   assign rel_full  = {1'b0, fno_ff} - {1'b0, base_ff};
   assign rel_bad_c = (fno_ff < base_ff) || (rel_full >= {5'd0, psize});
   assign rel_word  = word_of({5'd0, rel_ff});

   assign lo_rel    = {1'b0, lo_abs_ff} - {1'b0, base_ff};
   assign hi_rel_m1 = hi_abs_ff - {1'b0, base_ff} - 21'd1;

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = tag_ff;
      wr_data = rd_data_ff;
      case (dp_op)
         DP_INIT_WORD: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = init_word;
         end
         DP_SCAN: begin
            rd_en = !issued_ff;
            if (hit) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff & ~(32'd1 << hit_bit);
            end
         end
         DP_MARK: begin
            rd_en = !issued_ff;
            if (rdv_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff & ~mark_mask;
            end
         end
         DP_REL_READ: begin
            rd_en   = !rel_bad_ff;
            rd_addr = rel_word;
         end
         DP_REL_UPDATE: begin
            wr_en   = !rd_data_ff[rel_ff[BIT_W-1:0]];
            wr_addr = rel_word;
            wr_data = rd_data_ff | (32'd1 << rel_ff[BIT_W-1:0]);
         end
         default: ;
      endcase
   end

   assign scan_rd = rd_en && ((dp_op == DP_SCAN) || (dp_op == DP_MARK));

   always_ff @(posedge clock) begin
      if (wr_en) frame_map[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= frame_map[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= RST_BASE_FRAME;
         pool_ff <= RST_POOL_FRAMES;
         rsv_ff  <= RST_RESERVE;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BASE_FRAME:    base_ff <= csr_data;
            REG_POOL_FRAMES:   pool_ff <= csr_data[COUNT_W-1:0];
            REG_RESERVE_FIRST: rsv_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= 1'b1;
         pcv_ff    <= 1'b0;
      end else begin
         case (dp_op)
            DP_CAPTURE: begin
               fno_ff        <= req_start_frame;
               cnt_ff        <= req_range_count;
               res_frame_ff  <= '0;
               res_status_ff <= ST_OK;
            end
            DP_INIT_BEGIN: begin
               n_init_ff   <= psize;
               rsv_init_ff <= rsv_ff;
               ptr_ff      <= '0;
               free_ff     <= psize - {15'd0, rsv_ff && (psize != '0)};
            end
            DP_INIT_WORD: begin
               if (ptr_ff != LAST_WORD) ptr_ff <= ptr_ff + 1'b1;
            end
            DP_NOFREE: res_status_ff <= ST_NOFREE;
            DP_ALLOC_BEGIN: begin
               ptr_ff    <= '0;
               last_ff   <= word_of({5'd0, psize} - 21'd1);
               issued_ff <= 1'b0;
            end
            DP_SCAN: begin
               if (!issued_ff) begin
                  tag_ff    <= ptr_ff;
                  ptr_ff    <= ptr_ff + 1'b1;
                  issued_ff <= (ptr_ff == last_ff);
               end
               if (hit) begin
                  res_frame_ff <= alloc_frame[FRAME_W-1:0];
                  if (free_ff != '0) free_ff <= free_ff - 1'b1;
               end else if (scan_end) begin
                  res_status_ff <= ST_NOFREE;
               end
            end
            DP_PREP_A: begin
               end_ff  <= {1'b0, fno_ff} + {5'd0, cnt_ff};
               pend_ff <= {1'b0, base_ff} + {5'd0, psize};
            end
            DP_PREP_B: begin
               lo_abs_ff <= (fno_ff < base_ff) ? base_ff : fno_ff;
               hi_abs_ff <= (end_ff < pend_ff) ? end_ff : pend_ff;
               if ((cnt_ff != '0) && ((fno_ff < base_ff) || (end_ff > pend_ff))) begin
                  res_status_ff <= ST_RANGE;
               end
            end
            DP_MARK_BEGIN: begin
               ptr_ff    <= word_of(lo_rel);
               first_ff  <= word_of(lo_rel);
               last_ff   <= word_of(hi_rel_m1);
               lo_bit_ff <= lo_rel[BIT_W-1:0];
               hi_bit_ff <= hi_rel_m1[BIT_W-1:0];
               issued_ff <= 1'b0;
               pcv_ff    <= 1'b0;
            end
            DP_MARK: begin
               if (!issued_ff) begin
                  tag_ff    <= ptr_ff;
                  ptr_ff    <= ptr_ff + 1'b1;
                  issued_ff <= (ptr_ff == last_ff);
               end
               pc_ff  <= pop_count(rd_data_ff & mark_mask);
               pcv_ff <= rdv_ff;
               if (pcv_ff) begin
                  free_ff <= (free_ff > {10'd0, pc_ff}) ? free_ff - {10'd0, pc_ff} : '0;
               end
            end
            DP_REL_PREP: begin
               rel_ff     <= rel_full[COUNT_W-1:0];
               rel_bad_ff <= rel_bad_c;
            end
            DP_REL_READ: begin
               if (rel_bad_ff) res_status_ff <= ST_RANGE;
            end
            DP_REL_UPDATE: begin
               if (rd_data_ff[rel_ff[BIT_W-1:0]]) begin
                  res_status_ff <= ST_ALREADY;
               end else if (free_ff != 16'hFFFF) begin
                  free_ff <= free_ff + 1'b1;
               end
            end
            DP_LOAD: begin
               rsp_frame_ff  <= res_frame_ff;
               rsp_status_ff <= res_status_ff;
               rsp_free_ff   <= free_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      dp_status.init_last   = (ptr_ff == LAST_WORD);
      dp_status.free_zero   = (free_ff == '0);
      dp_status.pool_empty  = (psize == '0);
      dp_status.scan_hit    = hit;
      dp_status.scan_end    = scan_end;
      dp_status.range_empty = ({1'b0, lo_abs_ff} >= hi_abs_ff);
      dp_status.rel_bad     = rel_bad_ff;
   end

   assign rsp_frame_out  = rsp_frame_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

>>> rtl/bitmap_frame_allocator_top.sv
// First-fit bitmap frame allocator. A bitmap in on-chip RAM holds one bit per
// pool frame (1 free, 0used), 32 frames per RAM word, next to a 16-bit free
// count. Commands arrive as request transactions (req_tuser = command) and
// each yields exactly one response transaction: init (rebuild the map from
// the current registers), allocate (lowest free frame, returned as
// base_frame + index), mark a range used, or release one frame. Timing is
// set by the single-port-per-direction RAM walk: allocate reads one map word
// per cycle and stops at the first hit, skipping the walk when nothing is
// free; mark walks the words the range covers, skipping the walk when no
// pool frame is covered; release reads the frame's word and, if the frame
// is in the pool and used, writes it back; init rewrites all
// ceil(MAX_FRAMES/32) words. A finished command waits while the output
// register still holds a response not yet taken. One command is in flight
// at a time; a finished response sits in an output register while the next
// request is taken. After reset the block rebuilds the map with the reset
// registers with req_tready low; csr writes are accepted at any time but
// must only be issued while the block is idle.
`include "assert_macros.svh"

module bitmap_frame_allocator_top #(
   parameter int MAX_FRAMES = 32768
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bfa_pkg::DATA_W-1:0]    req_tdata,   // start frame, range_count, pad
   input  logic [1:0]                    req_tuser,   // cmd
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bfa_pkg::DATA_W-1:0]    rsp_tdata,   // frame_out, free_count, pad
   output logic [1:0]                    rsp_tuser,   // status
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::FRAME_W-1:0]   csr_data
);
   import bfa_pkg::*;

   dp_op_type          dp_op;
   dp_status_type      dp_status;
   logic [FRAME_W-1:0] rsp_frame_out;
   logic [COUNT_W-1:0] rsp_free_count;
   status_type         rsp_status;

   // register writes never stall
   assign csr_ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (cmd_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_op      (dp_op)
   );

   bfa_dpath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_start_frame (req_tdata[FRAME_W-1:0]),
      .req_range_count (req_tdata[FRAME_W+COUNT_W-1:FRAME_W]),
      .dp_op           (dp_op),
      .dp_status       (dp_status),
      .rsp_frame_out   (rsp_frame_out),
      .rsp_status      (rsp_status),
      .rsp_free_count  (rsp_free_count)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_free_count, rsp_frame_out};
   assign rsp_tuser = rsp_status;

   // a command occupies the block until its response is queued
   `ASSERT_NEXT(a_one_cmd_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while a command is in flight")
   // failed or non-allocate commands return frame zero
   `ASSERT_IMPLIES(a_fail_frame_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata[FRAME_W-1:0] == '0, "frame_out nonzero on failure")
   // a new response only follows command work
   `ASSERT_IMPLIES(a_rsp_after_work, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "response raised while idle")

endmodule

>>> tb/bitmap_frame_allocator_top_tb.sv
`timescale 1ns / 1ps

import bfa_pkg::*;

typedef struct packed {
   logic [FRAME_W-1:0] frame_out;
   status_type         status;
   logic [COUNT_W-1:0] free_count;
} alloc_reply_type;

// Shadow of the frame pool: bitmap, free count and registers, plus the
// replies owed by the block in command order.
class frame_pool_scoreboard #(int MAP_BITS = 32768);
   bit                 frame_free [MAP_BITS];
   logic [FRAME_W-1:0] base_frame;
   logic [COUNT_W-1:0] pool_frames;
   bit                 reserve_first;
   logic [COUNT_W-1:0] free_frames;
   alloc_reply_type    awaited_rsp [$];
   int unsigned        mismatches;
   int unsigned        replies_checked;

   function new();
      base_frame      = RST_BASE_FRAME;
      pool_frames     = RST_POOL_FRAMES;
      reserve_first   = RST_RESERVE;
      mismatches      = 0;
      replies_checked = 0;
      rebuild_map();
   endfunction

   function int unsigned pool_size();
      return (pool_frames > MAP_BITS) ? MAP_BITS : pool_frames;
   endfunction

   function int unsigned pending();
      return awaited_rsp.size();
   endfunction

   function void rebuild_map();
      int unsigned n;
      n = pool_size();
      for (int unsigned i = 0; i < MAP_BITS; i++)
         frame_free[i] = (i < n);
      free_frames = COUNT_W'(n);
      if (reserve_first && n > 0) begin
         frame_free[0] = 1'b0;
         free_frames   = COUNT_W'(n - 1);
      end
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
      case (idx)
         REG_BASE_FRAME:    base_frame    = val;
         REG_POOL_FRAMES:   pool_frames   = val[COUNT_W-1:0];
         REG_RESERVE_FIRST: reserve_first = val[0];
         default: ;
      endcase
   endfunction

   // Works out the reply to one accepted command and updates the shadow map.
   function void note_command(cmd_type cmd, logic [FRAME_W-1:0] fno,
                              logic [COUNT_W-1:0] cnt);
      alloc_reply_type   r;
      int unsigned       n;
      int unsigned       idx;
      bit                found;
      longint unsigned   first;
      longint unsigned   stop;
      longint unsigned   covered;
      n           = pool_size();
      r.frame_out = '0;
      r.status    = ST_OK;
      found       = 1'b0;
      idx         = 0;
      case (cmd)
         CMD_INIT: rebuild_map();
         CMD_ALLOC: begin
            if (free_frames != 0)
               for (int unsigned i = 0; i < n && !found; i++)
                  if (frame_free[i]) begin
                     idx   = i;
                     found = 1'b1;
                  end
            if (found) begin
               frame_free[idx] = 1'b0;
               if (free_frames != 0) free_frames--;
               r.frame_out = FRAME_W'(idx) + base_frame;
            end else begin
               r.status = ST_NOFREE;
            end
         end
         CMD_MARK: begin
            // no wrap of the absolute frame number: overlap of two ranges
            first = (fno > base_frame) ? fno : base_frame;
            stop  = longint'(fno) + cnt;
            if (stop > longint'(base_frame) + n) stop = longint'(base_frame) + n;
            covered = (stop > first) ? stop - first : 0;
            for (longint unsigned f = first; f < stop; f++) begin
               idx = int'(f - base_frame);
               if (frame_free[idx]) begin
                  frame_free[idx] = 1'b0;
                  if (free_frames != 0) free_frames--;
               end
            end
            if (covered != cnt) r.status = ST_RANGE;
         end
         default: begin
            if (fno < base_frame || longint'(fno - base_frame) >= n) begin
               r.status = ST_RANGE;
            end else begin
               idx = int'(fno - base_frame);
               if (frame_free[idx]) begin
                  r.status = ST_ALREADY;
               end else begin
                  frame_free[idx] = 1'b1;
                  if (free_frames != 16'hFFFF) free_frames++;
               end
            end
         end
      endcase
      r.free_count = free_frames;
      awaited_rsp.push_back(r);
   endfunction

   function void check_response(logic [FRAME_W-1:0] frame_out, status_type status,
                                logic [COUNT_W-1:0] free_count);
      alloc_reply_type want;
      replies_checked++;
      if (awaited_rsp.size() == 0) begin
         $error("response with nothing outstanding: frame_out %0d status %0d free_count %0d",
                frame_out, status, free_count);
         mismatches++;
         return;
      end
      want = awaited_rsp.pop_front();
      if (frame_out !== want.frame_out) begin
         $error("frame_out: expected %0d, got %0d", want.frame_out, frame_out);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         mismatches++;
      end
      if (free_count !== want.free_count) begin
         $error("free_count: expected %0d, got %0d", want.free_count, free_count);
         mismatches++;
      end
   endfunction
endclass

module bitmap_frame_allocator_top_tb;

   localparam int POOL_LIMIT = 32768;
   // random part stops once this many commands have gone out after the directed part
   localparam int RANDOM_CMDS = 525;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata;     // start frame, range_count, pad
   logic [1:0]           req_tuser;     // cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_W-1:0]    rsp_tdata;     // frame_out, free_count, pad
   logic [1:0]           rsp_tuser;     // status
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FRAME_W-1:0]   csr_data;

   frame_pool_scoreboard #(POOL_LIMIT) sb;

   int unsigned cmd_seen [4];
   int unsigned settings_used;
   int unsigned random_sent;
   int unsigned burst_left;

   // receiver stall pattern, rerolled every so often
   logic [15:0] ready_pattern = 16'hFFFF;
   int unsigned pattern_age   = 0;
   int unsigned tick          = 0;

   bitmap_frame_allocator_top #(
      .MAX_FRAMES (POOL_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: a 16-bit ready pattern, sometimes all ones so stretches run
   // with no backpressure at all. Bit 0 is forced so it never stalls forever.
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         pattern_age   = $urandom_range(40, 160);
         ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : (16'($urandom) | 16'h0001);
      end
      pattern_age--;
      tick++;
      rsp_tready = ready_pattern[tick % 16];
   end

   // Monitor. A response can never belong to the request taken at the same
   // edge, so checking before noting keeps the order right.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[FRAME_W-1:0], status_type'(rsp_tuser),
                              rsp_tdata[FRAME_W+COUNT_W-1:FRAME_W]);
         if (req_tvalid && req_tready) begin
            sb.note_command(cmd_type'(req_tuser), req_tdata[FRAME_W-1:0],
                            req_tdata[FRAME_W+COUNT_W-1:FRAME_W]);
            cmd_seen[req_tuser]++;
         end
      end
   end

   // Sender: bursts of random length, random gaps between them. Valid stays
   // high across back-to-back transactions inside a burst.
   task automatic issue(cmd_type cmd, logic [FRAME_W-1:0] fno, logic [COUNT_W-1:0] cnt);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {{PAD_W{1'b0}}, cnt, fno};
      do @(posedge clock); while (!req_tready);
   endtask

   // Let every owed response come back; the block is idle after that.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_pool(logic [FRAME_W-1:0] base, int unsigned frames, bit reserve);
      drain();
      write_csr(REG_BASE_FRAME, base);
      write_csr(REG_POOL_FRAMES, FRAME_W'(frames));
      write_csr(REG_RESERVE_FIRST, FRAME_W'(reserve));
      settings_used++;
   endtask

   // One random command aimed mostly at the current pool, with some noise.
   task automatic random_cmd();
      int unsigned        n;
      int unsigned        pick;
      cmd_type            op;
      logic [FRAME_W-1:0] fno;
      logic [COUNT_W-1:0] cnt;
      n    = sb.pool_size();
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = CMD_ALLOC;
      else if (pick < 70) op = CMD_RELEASE;
      else if (pick < 94) op = CMD_MARK;
      else                op = CMD_INIT;
      // low offsets are where allocations land, so releases there hit used frames
      if ($urandom_range(0, 1) == 0) fno = sb.base_frame + FRAME_W'($urandom_range(0, 63));
      else                           fno = sb.base_frame + FRAME_W'($urandom_range(0, n + 3));
      if ($urandom_range(0, 9) == 0) fno = FRAME_W'($urandom);
      case ($urandom_range(0, 39))
         0:       cnt = COUNT_W'($urandom);
         1, 2, 3: cnt = COUNT_W'($urandom_range(0, n + 8));
         default: cnt = COUNT_W'($urandom_range(0, 24));
      endcase
      issue(op, fno, cnt);
      random_sent++;
   endtask

   initial begin
      int unsigned        phase;
      int unsigned        frames;
      int unsigned        batch;
      logic [FRAME_W-1:0] base;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_INIT;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = REG_BASE_FRAME;
      csr_data      = '0;
      settings_used = 1;
      random_sent   = 0;
      burst_left    = 0;
      sb            = new();

      repeat (4) @(negedge clock);
      reset = 1'b0;
      // the block clears its map after reset with req_tready low
      @(posedge clock);
      do @(posedge clock); while (!req_tready);

      // Directed: reset settings, full pool with frame zero reserved
      issue(CMD_ALLOC,   20'd0,       16'd0);       // lowest free is frame one
      issue(CMD_RELEASE, 20'd0,       16'd0);       // reserved frame may be released
      issue(CMD_RELEASE, 20'd0,       16'd0);       // now already free
      issue(CMD_ALLOC,   20'd0,       16'd0);
      issue(CMD_RELEASE, 20'd32768,   16'd0);       // one past the pool
      issue(CMD_RELEASE, 20'hFFFFF,   16'd0);
      issue(CMD_MARK,    20'd32760,   16'd16);      // range hanging off the end
      issue(CMD_MARK,    20'd5,       16'd0);       // empty range is fine
      issue(CMD_MARK,    20'hFFFFF,   16'hFFFF);    // wholly outside
      issue(CMD_MARK,    20'd100,     16'd32768);   // covers the rest of the pool
      issue(CMD_ALLOC,   20'd0,       16'd0);
      issue(CMD_RELEASE, 20'd32767,   16'd0);

      // empty pool: nothing to reserve, nothing to hand out
      set_pool(20'hFFFFF, 0, 1'b1);
      issue(CMD_INIT,    20'd0,       16'd0);
      issue(CMD_ALLOC,   20'd0,       16'd0);
      issue(CMD_RELEASE, 20'hFFFFF,   16'd0);
      issue(CMD_MARK,    20'hFFFFF,   16'd1);

      // pool at the top of the frame space: allocations wrap past zero,
      // then the count runs dry
      set_pool(20'hFFFF8, 10, 1'b1);
      issue(CMD_INIT, 20'd0, 16'd0);
      repeat (10) issue(CMD_ALLOC, 20'd0, 16'd0);

      // Random phases. Every ninth uses a large pool; every fourth changes
      // the registers without init, so stale bits outside the pool stay put.
      phase = 0;
      while (random_sent < RANDOM_CMDS) begin
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = 20'hFFFFF - FRAME_W'($urandom_range(0, 300));
            default: base = FRAME_W'($urandom);
         endcase
         if (phase % 9 == 4) begin
            case ($urandom_range(0, 2))
               0:       frames = 32768;
               1:       frames = 65535;   // clipped to the map size
               default: frames = $urandom_range(1000, 32768);
            endcase
         end else if ($urandom_range(0, 7) == 0) begin
            frames = $urandom_range(1, 4);
         end else begin
            frames = $urandom_range(1, 300);
         end
         set_pool(base, frames, 1'($urandom));
         if (phase % 4 != 3) issue(CMD_INIT, 20'd0, 16'd0);
         batch = $urandom_range(15, 35);
         repeat (batch) random_cmd();
         phase++;
      end

      drain();
      repeat (64) @(posedge clock);

      $display("Covered %0d commands: init %0d, allocate %0d, mark %0d, release %0d;",
               cmd_seen[CMD_INIT] + cmd_seen[CMD_ALLOC] + cmd_seen[CMD_MARK]
               + cmd_seen[CMD_RELEASE], cmd_seen[CMD_INIT], cmd_seen[CMD_ALLOC],
               cmd_seen[CMD_MARK], cmd_seen[CMD_RELEASE]);
      $display("%0d responses checked across %0d register settings.",
               sb.replies_checked, settings_used);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("bitmap_frame_allocator_top_tb passed");
      end else begin
         $display("bitmap_frame_allocator_top_tb failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run (every command a full
   // map walk plus the longest stalls on both sides).
   initial begin
      #80_000_000;
      $display("bitmap_frame_allocator_top_tb failed");
      $finish;
   end

endmodule
